// ----- sv/tnlt_pkg.sv -----
// ----------------------------------------------------------------------------
// tnlt_pkg
// Shared types and constants of the node liveness table.
// ----------------------------------------------------------------------------
package tnlt_pkg;

    // command codes
    localparam logic [1:0] CMD_UPSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_ASSIGN = 2'd3;

    // entry status codes
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_ACTIVE  = 2'd1;
    localparam logic [1:0] ST_SUSPECT = 2'd2;
    localparam logic [1:0] ST_LOST    = 2'd3;

    localparam logic [7:0]  NO_SLOT     = 8'hff;
    localparam logic [7:0]  FIRST_SLOT  = 8'd2;
    localparam logic [15:0] SILENCE_MAX = 16'hffff;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_MASTER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUSPECT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOST    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECLAIM = 8'd3;

    localparam logic [7:0]  MASTER_RST  = 8'd0;
    localparam logic [15:0] SUSPECT_RST = 16'd3;
    localparam logic [15:0] LOST_RST    = 16'd6;
    localparam logic [15:0] RECLAIM_RST = 16'd10;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  node;
        logic [7:0]  slot;
        logic [15:0] silence;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{ST_FREE, 8'd0, NO_SLOT, 16'd0};

    typedef struct packed {
        logic [7:0]  master;
        logic [15:0] suspect_after;
        logic [15:0] lost_after;
        logic [15:0] reclaim_after;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] node_id;
        logic [7:0] slot_next;
        entry_t     entry;
    } unit_in_t;

    typedef struct packed {
        logic   match;
        logic   is_free;
        logic   wr_en;
        entry_t wr_entry;
        logic   reclaim;
        logic   slot_used;
    } unit_out_t;

    typedef struct packed {
        logic        hit;
        logic        created;
        logic [3:0]  entry_index;
        logic [1:0]  node_status;
        logic [7:0]  slot_number;
        logic [15:0] silent_frames;
        logic [4:0]  occupied_count;
    } result_t;

endpackage

// ----- sv/tnlt_ram.sv -----
// ----------------------------------------------------------------------------
// tnlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tnlt_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/tnlt_unit.sv -----
// ----------------------------------------------------------------------------
// tnlt_unit
// Shared entry evaluation unit: id compare, saturating silence increment,
// threshold compares and slot numbering for one entry per cycle.
// ----------------------------------------------------------------------------
module tnlt_unit (
    input  tnlt_pkg::cfg_t      cfg,
    input  tnlt_pkg::unit_in_t  uin,
    output tnlt_pkg::unit_out_t uout
);
    import tnlt_pkg::*;

    logic        occupied;
    logic [15:0] sil_inc;

    assign occupied = (uin.entry.status != ST_FREE);
    assign sil_inc  = (uin.entry.silence == SILENCE_MAX) ? uin.entry.silence
                                                         : uin.entry.silence + 16'd1;

    always_comb
    begin
        uout.match     = 1'b0;
        uout.is_free   = !occupied;
        uout.wr_en     = 1'b0;
        uout.wr_entry  = uin.entry;
        uout.reclaim   = 1'b0;
        uout.slot_used = 1'b0;
        case (uin.cmd)
            CMD_UPSERT, CMD_FIND:
            begin
                uout.match = occupied && (uin.entry.node == uin.node_id);
            end
            CMD_TICK:
            begin
                if (occupied && (uin.entry.node != cfg.master))
                begin
                    uout.wr_en            = 1'b1;
                    uout.wr_entry.silence = sil_inc;
                    case (uin.entry.status)
                        ST_ACTIVE:
                        begin
                            if (sil_inc >= cfg.suspect_after)
                            begin
                                uout.wr_entry.status = ST_SUSPECT;
                            end
                        end
                        ST_SUSPECT:
                        begin
                            if (sil_inc >= cfg.lost_after)
                            begin
                                uout.wr_entry.status = ST_LOST;
                            end
                        end
                        ST_LOST:
                        begin
                            if (sil_inc >= cfg.reclaim_after)
                            begin
                                uout.wr_entry.status = ST_FREE;
                                uout.wr_entry.node   = 8'd0;
                                uout.wr_entry.slot   = NO_SLOT;
                                uout.reclaim         = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            CMD_ASSIGN:
            begin
                if (occupied)
                begin
                    uout.wr_en         = 1'b1;
                    uout.wr_entry.slot = uin.slot_next;
                    uout.slot_used     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/tnlt_seq.sv -----
// ----------------------------------------------------------------------------
// tnlt_seq
// Command sequencer: scans the entry RAM one entry per cycle through the
// shared evaluation unit, then claims a free entry or builds the result.
// ----------------------------------------------------------------------------
module tnlt_seq #(
    parameter int MAX_NODES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tnlt_pkg::cfg_t                     cfg,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  logic [1:0]                         cmd,
    input  logic [7:0]                         node_id,
    output logic                               res_valid,
    input  logic                               res_ready,
    output tnlt_pkg::result_t                  res,
    output logic [$clog2(MAX_NODES+1)-1:0]     occ
);
    import tnlt_pkg::*;

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_NODES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_CREATE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [7:0]           id_reg, id_next;
    logic [CNT_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]     ev_idx_reg, ev_idx_next;
    logic                 match_reg, match_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    entry_t               match_entry_reg, match_entry_next;
    logic                 free_reg, free_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic                 created_reg, created_next;
    logic [7:0]           slot_reg, slot_next;
    logic [MAX_NODES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;

    logic                 rd_en;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_entry;
    entry_t               rd_entry;
    entry_t               entry_cur;
    unit_in_t             uin;
    unit_out_t            uout;

    assign rd_en = (state_reg == S_SCAN) && (rd_ptr_reg != LAST_CNT);

    tnlt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg[IDX_W-1:0]),
        .rd_data (rd_entry)
    );

    // entries never written since reset read as free
    assign entry_cur = valid_reg[ev_idx_reg] ? rd_entry : ENTRY_RESET;

    assign uin.cmd       = cmd_reg;
    assign uin.node_id   = id_reg;
    assign uin.slot_next = slot_reg;
    assign uin.entry     = entry_cur;

    tnlt_unit u_unit (
        .cfg  (cfg),
        .uin  (uin),
        .uout (uout)
    );

    always_comb
    begin
        if (state_reg == S_CREATE)
        begin
            wr_en    = 1'b1;
            wr_addr  = free_idx_reg;
            wr_entry = '{ST_ACTIVE, id_reg, NO_SLOT, 16'd0};
        end
        else
        begin
            wr_en    = (state_reg == S_SCAN) && ev_valid_reg && uout.wr_en;
            wr_addr  = ev_idx_reg;
            wr_entry = uout.wr_entry;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        rd_ptr_next      = rd_ptr_reg;
        ev_valid_next    = ev_valid_reg;
        ev_idx_next      = ev_idx_reg;
        match_next       = match_reg;
        match_idx_next   = match_idx_reg;
        match_entry_next = match_entry_reg;
        free_next        = free_reg;
        free_idx_next    = free_idx_reg;
        created_next     = created_reg;
        slot_next        = slot_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd;
                    id_next       = node_id;
                    rd_ptr_next   = '0;
                    ev_valid_next = 1'b0;
                    match_next    = 1'b0;
                    free_next     = 1'b0;
                    created_next  = 1'b0;
                    slot_next     = FIRST_SLOT;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ev_valid_next = rd_en;
                ev_idx_next   = rd_ptr_reg[IDX_W-1:0];
                if (rd_en)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_ONE;
                end
                if (ev_valid_reg)
                begin
                    if (uout.match && !match_reg)
                    begin
                        match_next       = 1'b1;
                        match_idx_next   = ev_idx_reg;
                        match_entry_next = entry_cur;
                    end
                    if (uout.is_free && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = ev_idx_reg;
                    end
                    if (uout.reclaim)
                    begin
                        occ_next = occ_reg - CNT_ONE;
                    end
                    if (uout.slot_used)
                    begin
                        slot_next = slot_reg + 8'd1;
                    end
                end
                else if (!rd_en)
                begin
                    // every entry has gone through the unit
                    if ((cmd_reg == CMD_UPSERT) && !match_reg && free_reg)
                    begin
                        state_next = S_CREATE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CREATE:
            begin
                created_next            = 1'b1;
                valid_next[free_idx_reg] = 1'b1;
                occ_next                = occ_reg + CNT_ONE;
                state_next              = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= CMD_UPSERT;
            id_reg          <= '0;
            rd_ptr_reg      <= '0;
            ev_valid_reg    <= 1'b0;
            ev_idx_reg      <= '0;
            match_reg       <= 1'b0;
            match_idx_reg   <= '0;
            match_entry_reg <= ENTRY_RESET;
            free_reg        <= 1'b0;
            free_idx_reg    <= '0;
            created_reg     <= 1'b0;
            slot_reg        <= FIRST_SLOT;
            valid_reg       <= '0;
            occ_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            id_reg          <= id_next;
            rd_ptr_reg      <= rd_ptr_next;
            ev_valid_reg    <= ev_valid_next;
            ev_idx_reg      <= ev_idx_next;
            match_reg       <= match_next;
            match_idx_reg   <= match_idx_next;
            match_entry_reg <= match_entry_next;
            free_reg        <= free_next;
            free_idx_reg    <= free_idx_next;
            created_reg     <= created_next;
            slot_reg        <= slot_next;
            valid_reg       <= valid_next;
            occ_reg         <= occ_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign occ       = occ_reg;

    always_comb
    begin
        res.hit            = match_reg || created_reg;
        res.created        = created_reg;
        res.occupied_count = 5'(occ_reg);
        if (created_reg)
        begin
            res.entry_index   = 4'(free_idx_reg);
            res.node_status   = ST_ACTIVE;
            res.slot_number   = NO_SLOT;
            res.silent_frames = 16'd0;
        end
        else if (match_reg)
        begin
            res.entry_index   = 4'(match_idx_reg);
            res.node_status   = match_entry_reg.status;
            res.slot_number   = match_entry_reg.slot;
            res.silent_frames = match_entry_reg.silence;
        end
        else
        begin
            res.entry_index   = 4'd0;
            res.node_status   = ST_FREE;
            res.slot_number   = 8'd0;
            res.silent_frames = 16'd0;
        end
    end

endmodule

// ----- sv/tdma_node_liveness_table.sv -----
// ----------------------------------------------------------------------------
// tdma_node_liveness_table
// Table of network nodes with status ageing, lookup and slot numbering.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command beat: cmd (upsert, find, tick, assign) and node_id.
//   m_* returns exactly one result beat per command.
//   cfg_* writes the master id and the three ageing thresholds; always ready;
//   it must be written only while no command is in flight (the block does not enforce this).
// Scan:
//   every command scans all MAX_NODES entries, one entry per cycle through
//   the single read port of the entry RAM and the shared evaluation unit;
//   an upsert that misses then claims a free entry if one is left, and s_tready
//   is low from accept until the result is passed to the output register.
// Reset:
//   all entries read as free at once (per-entry valid flops), thresholds go
//   to their defaults, no result pending; no clearing pass is needed.
// Stall:
//   a result waits in the output register while m_tready is low; the next
//   command may be accepted meanwhile and holds in its last step until the
//   output register drains.
// ----------------------------------------------------------------------------
module tdma_node_liveness_table #(
    parameter int MAX_NODES = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // cmd[1:0], node_id[9:2], zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit[0], created[1], entry_index[5:2], node_status[7:6], slot_number[15:8],
    // silent_frames[31:16], occupied_count[36:32], zero pad
    output logic [39:0]                        m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tnlt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);
    import tnlt_pkg::*;

    localparam int CNT_W = $clog2(MAX_NODES + 1);

    logic [7:0]       master_reg, master_next;
    logic [15:0]      suspect_reg, suspect_next;
    logic [15:0]      lost_reg, lost_next;
    logic [15:0]      reclaim_reg, reclaim_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [39:0]      m_tdata_reg, m_tdata_next;

    cfg_t             cfg;
    logic             res_valid;
    logic             res_ready;
    result_t          res;
    logic [CNT_W-1:0] occ;

    assign cfg.master        = master_reg;
    assign cfg.suspect_after = suspect_reg;
    assign cfg.lost_after    = lost_reg;
    assign cfg.reclaim_after = reclaim_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    tnlt_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (s_tdata[1:0]),
        .node_id   (s_tdata[9:2]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .occ       (occ)
    );

    assign cfg_ready = 1'b1;

    always_comb
    begin
        master_next  = master_reg;
        suspect_next = suspect_reg;
        lost_next    = lost_reg;
        reclaim_next = reclaim_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MASTER:  master_next  = cfg_data[7:0];
                REG_SUSPECT: suspect_next = cfg_data;
                REG_LOST:    lost_next    = cfg_data;
                REG_RECLAIM: reclaim_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, res.occupied_count, res.silent_frames,
                             res.slot_number, res.node_status, res.entry_index,
                             res.created, res.hit};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            master_reg   <= MASTER_RST;
            suspect_reg  <= SUSPECT_RST;
            lost_reg     <= LOST_RST;
            reclaim_reg  <= RECLAIM_RST;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            master_reg   <= master_next;
            suspect_reg  <= suspect_next;
            lost_reg     <= lost_next;
            reclaim_reg  <= reclaim_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // occupancy counter never leaves the table size
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ <= CNT_W'(MAX_NODES))
        else $error("occupied count beyond table size");

    // a command scan always occupies the sequencer past the accept beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accepting a command");

    // a created entry is always reported as a hit
    a_created_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("created without hit");

    // a miss carries zero entry fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[31:1] == 31'd0))
        else $error("miss result with nonzero entry fields");
`endif

endmodule
